FILE: sv/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by every module of the block.
package dq_pkg;

    localparam int DEPTH         = 1024;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int SUM_W         = IDX_W + 1;
    localparam int DATA_W        = 32;
    localparam int ENTRY_COUNT_W = 11;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 112;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic finish;
        logic out_load;
    } dq_cmd_t;

    typedef struct packed {
        logic need_fetch;
    } dq_status_t;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        d = s - SUM_W'(DEPTH);
        if (s >= SUM_W'(DEPTH))
        begin
            return d[IDX_W-1:0];
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

FILE: sv/dq_ctrl.sv
// Controller for the double-ended queue: beat acceptance, refill wait, result register.
// Depends on dq_pkg.
module dq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  dq_pkg::dq_status_t status,
    output dq_pkg::dq_cmd_t    cmd
);
    import dq_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && out_free && status.need_fetch)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.finish   = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready     = out_free;
                cmd.accept   = s_tvalid && out_free;
                cmd.out_load = s_tvalid && out_free && !status.need_fetch;
            end
            ST_FETCH:
            begin
                cmd.finish   = out_free;
                cmd.out_load = out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/dq_datapath.sv
// Datapath for the double-ended queue: ring store, head and count, cached ends, result register.
// Depends on dq_pkg.
module dq_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dq_pkg::dq_cmd_t                        cmd,
    output dq_pkg::dq_status_t                     status,
    input  logic [2:0]                             opcode,
    input  logic signed [dq_pkg::DATA_W-1:0]       push_value,
    output logic signed [dq_pkg::DATA_W-1:0]       popped_value,
    output logic                                   popped_valid,
    output logic                                   push_dropped,
    output logic [dq_pkg::ENTRY_COUNT_W-1:0]       entry_count,
    output logic                                   is_empty,
    output logic signed [dq_pkg::DATA_W-1:0]       front_value,
    output logic signed [dq_pkg::DATA_W-1:0]       back_value,
    output logic                                   ends_valid
);
    import dq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] back_reg, back_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] pend_popped_reg;
    logic              pend_front_reg;

    logic [DATA_W-1:0] out_popped_reg, out_front_reg, out_back_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_pvalid_reg, out_dropped_reg, out_nonempty_reg;

    logic [IDX_W-1:0]  head_dec, head_inc, tail_addr, back2_addr;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic              wr_en;
    logic [DATA_W-1:0] popped;
    logic              pvalid, dropped, full, empty, many;

    assign full  = (count_reg >= CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign many  = (count_reg >= CNT_W'(2));

    assign head_dec   = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc   = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_addr  = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg));
    assign back2_addr = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(2));

    always_comb
    begin
        head_next         = head_reg;
        count_next        = count_reg;
        front_next        = front_reg;
        back_next         = back_reg;
        popped            = '0;
        pvalid            = 1'b0;
        dropped           = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = tail_addr;
        rd_addr           = head_inc;
        status.need_fetch = 1'b0;
        unique case (opcode_t'(opcode))
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                    front_next = push_value;
                    if (empty)
                    begin
                        back_next = push_value;
                    end
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = tail_addr;
                    count_next = count_reg + 1'b1;
                    back_next  = push_value;
                    if (empty)
                    begin
                        front_next = push_value;
                    end
                end
            end
            OP_POP_FRONT:
            begin
                if (!empty)
                begin
                    pvalid            = 1'b1;
                    popped            = front_reg;
                    head_next         = head_inc;
                    count_next        = count_reg - 1'b1;
                    rd_addr           = head_inc;
                    status.need_fetch = many;
                end
            end
            OP_POP_BACK:
            begin
                if (!empty)
                begin
                    pvalid            = 1'b1;
                    popped            = back_reg;
                    count_next        = count_reg - 1'b1;
                    rd_addr           = back2_addr;
                    status.need_fetch = many;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            front_reg       <= front_next;
            back_reg        <= back_next;
            pend_popped_reg <= popped;
            pend_front_reg  <= (opcode_t'(opcode) == OP_POP_FRONT);
        end
        else if (cmd.finish)
        begin
            if (pend_front_reg)
            begin
                front_reg <= rd_data_reg;
            end
            else
            begin
                back_reg <= rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.finish)
            begin
                out_popped_reg   <= pend_popped_reg;
                out_pvalid_reg   <= 1'b1;
                out_dropped_reg  <= 1'b0;
                out_count_reg    <= count_reg;
                out_nonempty_reg <= 1'b1;
                out_front_reg    <= pend_front_reg ? rd_data_reg : front_reg;
                out_back_reg     <= pend_front_reg ? back_reg : rd_data_reg;
            end
            else
            begin
                out_popped_reg   <= popped;
                out_pvalid_reg   <= pvalid;
                out_dropped_reg  <= dropped;
                out_count_reg    <= count_next;
                out_nonempty_reg <= (count_next != '0);
                out_front_reg    <= front_next;
                out_back_reg     <= back_next;
            end
        end
    end

    assign popped_value = out_popped_reg;
    assign popped_valid = out_pvalid_reg;
    assign push_dropped = out_dropped_reg;
    assign entry_count  = ENTRY_COUNT_W'(out_count_reg);
    assign is_empty     = !out_nonempty_reg;
    assign ends_valid   = out_nonempty_reg;
    assign front_value  = out_nonempty_reg ? out_front_reg : '0;
    assign back_value   = out_nonempty_reg ? out_back_reg : '0;

endmodule

FILE: sv/double_ended_queue.sv
// Top level of the double-ended queue: stream ports, controller and datapath.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
// A deque of signed 32-bit values in a ring store of DEPTH slots (1024), with
// the front and back values held in registers. One command beat in, one result
// beat out. Pushes, queries and pops that empty the store or find it empty load
// the result directly; a pop that leaves one or more entries first waits in the
// fetch state, since the new end value comes through the store's single registered
// read port. A full result register that is not taken holds off the next command.
// No clearing pass is needed after reset. Push into a full store is dropped and
// flagged; pop from an empty store reports popped_valid low.
module double_ended_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] opcode, [34:3] push_value, [39:35] zero
    input  logic [dq_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] popped_value, [32] popped_valid, [33] push_dropped,
    // [44:34] entry_count, [45] is_empty, [77:46] front_value,
    // [109:78] back_value, [110] ends_valid, [111] zero
    output logic [dq_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import dq_pkg::*;

    dq_cmd_t    cmd;
    dq_status_t status;

    logic signed [DATA_W-1:0]  popped_value, front_value, back_value;
    logic                      popped_valid, push_dropped, is_empty, ends_valid;
    logic [ENTRY_COUNT_W-1:0]  entry_count;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (s_tdata[2:0]),
        .push_value   (s_tdata[34:3]),
        .popped_value (popped_value),
        .popped_valid (popped_valid),
        .push_dropped (push_dropped),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .front_value  (front_value),
        .back_value   (back_value),
        .ends_valid   (ends_valid)
    );

    assign m_tdata = {1'b0, ends_valid, back_value, front_value, is_empty,
                      entry_count, push_dropped, popped_valid, popped_value};

    a_fetch_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && status.need_fetch) |=> !s_tready)
        else $error("refill pop did not hold off the next command");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (entry_count <= ENTRY_COUNT_W'(DEPTH)))
        else $error("entry count beyond store depth");

    a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((is_empty == (entry_count == '0)) && (ends_valid == !is_empty)))
        else $error("empty and ends flags disagree with count");

    a_pop_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(popped_valid && push_dropped))
        else $error("result flags both a pop and a dropped push");

endmodule
